// ----- src/sv32ptw_pkg.sv -----
`default_nettype none
package sv32ptw_pkg;

   localparam int XLEN       = 32;
   localparam int PPN_W      = 20;
   localparam int VPN_W      = 10;
   localparam int PAGE_OFS_W = 12;
   localparam int PTE_PPN_LO = 10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_ROOT_PAGE_NUMBER = 1'b0;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_RESPONSE  = 1'b1;

   localparam logic [1:0] ACCESS_WRITE = 2'd2;

   localparam logic [XLEN-1:0] ENTRY_VALID    = 32'h0000_0001;
   localparam logic [XLEN-1:0] ENTRY_ACCESSED = 32'h0000_0040;
   localparam logic [XLEN-1:0] ENTRY_DIRTY    = 32'h0000_0080;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_L1   = 2'd1,
      PHASE_L2   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_FAULT = 2'd3
   } kind_type;

   typedef struct packed {
      logic             op;
      logic [XLEN-1:0]  virtual_address;
      logic [1:0]       access_type;
      logic [XLEN-1:0]  read_data;
   } req_word_type;

   typedef struct packed {
      kind_type         kind;
      logic [XLEN-1:0]  address;
      logic [XLEN-1:0]  write_data;
      logic             fault_level;
      logic             last;
   } rsp_word_type;

   // results of one word going into the response queue
   typedef struct packed {
      logic [1:0]    count;
      rsp_word_type  r0;
      rsp_word_type  r1;
   } push_type;

   function automatic rsp_word_type make_rsp(
      input kind_type        kind,
      input logic [XLEN-1:0] address,
      input logic [XLEN-1:0] write_data,
      input logic            fault_level,
      input logic            last
   );
      rsp_word_type r;
      r.kind        = kind;
      r.address     = address;
      r.write_data  = write_data;
      r.fault_level = fault_level;
      r.last        = last;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/sv32ptw_req_if.sv -----
`default_nettype none
interface sv32ptw_req_if;
   import sv32ptw_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [XLEN-1:0]   virtual_address;
   logic [1:0]        access_type;
   logic [XLEN-1:0]   read_data;

   modport source (output valid, op, virtual_address, access_type, read_data, input ready);
   modport sink   (input valid, op, virtual_address, access_type, read_data, output ready);
endinterface
`default_nettype wire

// ----- src/sv32ptw_rsp_if.sv -----
`default_nettype none
interface sv32ptw_rsp_if;
   import sv32ptw_pkg::*;

   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [XLEN-1:0]   address;
   logic [XLEN-1:0]   write_data;
   logic              fault_level;
   logic              last;

   modport source (output valid, kind, address, write_data, fault_level, last, input ready);
   modport sink   (input valid, kind, address, write_data, fault_level, last, output ready);
endinterface
`default_nettype wire

// ----- src/sv32ptw_walk.sv -----
`default_nettype none
module sv32ptw_walk (
   input  logic                                  clock,
   input  logic                                  reset,
   sv32ptw_req_if.sink                           req_ch,
   input  logic [sv32ptw_pkg::PPN_W-1:0]         root_page_number,
   input  logic                                  room,
   output sv32ptw_pkg::push_type                 push
);
   import sv32ptw_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   req_word_type     s1_word_ff, s1_word_in;
   phase_type        phase_ff, phase_in;
   logic [XLEN-1:0]  saved_va_ff, saved_va_in;
   logic [1:0]       saved_at_ff, saved_at_in;
   logic [XLEN-1:0]  leaf_addr_ff, leaf_addr_in;
   logic             advance;
   logic             take;
   logic             busy;
   logic [XLEN-1:0]  pte;
   logic [XLEN-1:0]  upd;

   assign advance      = s1_valid_ff && room;
   assign req_ch.ready = !s1_valid_ff || room;
   assign take         = req_ch.valid && req_ch.ready;

   assign s1_word_in.op              = req_ch.op;
   assign s1_word_in.virtual_address = req_ch.virtual_address;
   assign s1_word_in.access_type     = req_ch.access_type;
   assign s1_word_in.read_data       = req_ch.read_data;

   always_comb begin
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign busy = (phase_ff == PHASE_L1) || (phase_ff == PHASE_L2);
   assign pte  = s1_word_ff.read_data;
   assign upd  = pte | ENTRY_ACCESSED |
                 ((saved_at_ff == ACCESS_WRITE) ? ENTRY_DIRTY : '0);

   always_comb begin
      phase_in     = phase_ff;
      saved_va_in  = saved_va_ff;
      saved_at_in  = saved_at_ff;
      leaf_addr_in = leaf_addr_ff;
      push.count   = 2'd0;
      push.r0      = '0;
      push.r1      = '0;
      if (advance) begin
         if (s1_word_ff.op == OP_TRANSLATE) begin
            if (!busy) begin
               saved_va_in = s1_word_ff.virtual_address;
               saved_at_in = s1_word_ff.access_type;
               phase_in    = PHASE_L1;
               push.count  = 2'd1;
               push.r0     = make_rsp(KIND_READ,
                  {root_page_number, s1_word_ff.virtual_address[XLEN-1 -: VPN_W], 2'b00},
                  '0, 1'b0, 1'b1);
            end
         end else begin
            unique case (phase_ff)
               PHASE_L1: begin
                  push.count = 2'd1;
                  if (!pte[0]) begin
                     phase_in = PHASE_IDLE;
                     push.r0  = make_rsp(KIND_FAULT, '0, '0, 1'b0, 1'b1);
                  end else begin
                     // upper entry ppn bits drop out of the 32-bit address
                     leaf_addr_in = {pte[PTE_PPN_LO +: PPN_W],
                                     saved_va_ff[PAGE_OFS_W +: VPN_W], 2'b00};
                     phase_in     = PHASE_L2;
                     push.r0      = make_rsp(KIND_READ, leaf_addr_in, '0, 1'b0, 1'b1);
                  end
               end
               PHASE_L2: begin
                  phase_in = PHASE_IDLE;
                  if (!pte[0]) begin
                     push.count = 2'd1;
                     push.r0    = make_rsp(KIND_FAULT, '0, '0, 1'b1, 1'b1);
                  end else begin
                     push.count = 2'd2;
                     push.r0    = make_rsp(KIND_WRITE, leaf_addr_ff, upd, 1'b0, 1'b0);
                     push.r1    = make_rsp(KIND_DONE,
                        {pte[PTE_PPN_LO +: PPN_W], saved_va_ff[PAGE_OFS_W-1:0]},
                        '0, 1'b0, 1'b1);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PHASE_IDLE;
         saved_va_ff  <= '0;
         saved_at_ff  <= '0;
         leaf_addr_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         saved_va_ff  <= saved_va_in;
         saved_at_ff  <= saved_at_in;
         leaf_addr_ff <= leaf_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_word_ff <= s1_word_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/sv32ptw_rspq.sv -----
`default_nettype none
module sv32ptw_rspq (
   input  logic                    clock,
   input  logic                    reset,
   input  sv32ptw_pkg::push_type   push,
   output logic                    room,
   sv32ptw_rsp_if.source           rsp_ch
);
   import sv32ptw_pkg::*;

   rsp_word_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic [QPTR_W-1:0]  wr_next;
   logic               pop;
   rsp_word_type       head;

   assign pop     = rsp_ch.valid && rsp_ch.ready;
   assign wr_next = wr_ff + 1'b1;
   // two free slots, so a word with two results always fits
   assign room    = count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);

   assign wr_in    = wr_ff + QPTR_W'(push.count);
   assign rd_in    = rd_ff + QPTR_W'(pop);
   assign count_in = count_ff + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.r1;
      end
   end

   assign head               = mem_ff[rd_ff];
   assign rsp_ch.valid       = count_ff != '0;
   assign rsp_ch.kind        = head.kind;
   assign rsp_ch.address     = head.address;
   assign rsp_ch.write_data  = head.write_data;
   assign rsp_ch.fault_level = head.fault_level;
   assign rsp_ch.last        = head.last;

endmodule
`default_nettype wire

// ----- src/sv32ptw_top.sv -----
`default_nettype none
// two-level sv32 page table walker
// req_ch carries a translate request (op 0: virtual address, access type) or a
// memory read response (op 1: entry data). rsp_ch returns memory read requests,
// entry write-backs, the translated physical address or a fault.
// a translate request yields one read of the first-level entry; the first
// response yields a read of the leaf entry or a fault; the second response
// yields a fault, or a write-back followed by the physical address (last set).
// requests while a walk is open and responses while idle are dropped silently.
// a word is registered at the input, worked from that register once the queue
// has room, and its results sit in a four-entry queue that drives rsp_ch.
// one word is accepted per cycle while the queue has room; results drain one
// per cycle, so words that make two results slow intake only when they pile up.
// a stalled receiver fills the queue; intake stops once fewer than two slots
// remain free, and resumes as results are taken.
// reset (synchronous, active high) ends any open walk, empties the queue and
// clears root_page_number, written through the csr port at byte address 0.
module sv32_page_table_walker_top (
   input  logic                                  clock,
   input  logic                                  reset,
   sv32ptw_req_if.sink                           req_ch,
   sv32ptw_rsp_if.source                         rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sv32ptw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import sv32ptw_pkg::*;

   logic [PPN_W-1:0]  root_ff, root_in;
   logic              csr_write;
   logic              room;
   push_type          push;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      root_in = root_ff;
      if (csr_write && (csr_paddr[2] == REG_ROOT_PAGE_NUMBER)) begin
         root_in = csr_pwdata[PPN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ROOT_PAGE_NUMBER) ?
                       {{(32-PPN_W){1'b0}}, root_ff} : '0;

   sv32ptw_walk u_walk (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .root_page_number (root_ff),
      .room             (room),
      .push             (push)
   );

   sv32ptw_rspq u_rspq (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed into a full queue");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.r0.kind == KIND_WRITE && !push.r0.last &&
                                push.r1.kind == KIND_DONE && push.r1.last))
      else $error("write-back and done pair out of order");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd1) |-> (push.r0.last && push.r0.kind != KIND_WRITE &&
                                push.r0.kind != KIND_DONE))
      else $error("single result of a word malformed");

   a_pop_after_push: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |=> rsp_ch.valid)
      else $error("pushed result not visible on rsp_ch");

endmodule
`default_nettype wire
